>>> design/zcpm_pkg.sv
package zcpm_pkg;

    // Default widths of the sample, the tick counter and the fraction.
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int TICK_BITS_DEF     = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // Configuration port.
    localparam int         APB_ADDR_BITS   = 3;
    localparam int         APB_DATA_BITS   = 32;
    localparam logic       REG_WARMUP      = 1'b0;
    localparam logic [7:0] WARMUP_RESET    = 8'd12;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // take the word on the sample port
        logic div_step;  // run one quotient bit of the fraction divider
        logic load_out;  // write the result register and finish the crossing
    } t_zcpm_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic crossing;  // the word on the sample port is a rising crossing
        logic div_last;  // the current divider step produces the last bit
    } t_zcpm_sts;

endpackage

>>> design/zero_crossing_period_meter.sv
// Channel   Direction  Handshake                        Payload
// sample    in         i_sample_valid / o_sample_stall  i_sample
// result    out        o_result_valid / i_result_stall  o_period_q16, o_crossing_fraction
// config    in         APB write/read, pready always 1  warmup_samples at byte address 0
//
// A word that is still in warm-up or is no rising zero crossing is taken and the next word is not stalled.
// A rising crossing is accepted, then the bit-serial fraction divider forms its quotient
// bit by bit, and a finish step forms and stores the period; the sample port stalls meanwhile.
// The finish step waits while the result register still holds a word that is stalled.
// Reset is synchronous and active low and has no clearing pass.
module zero_crossing_period_meter import zcpm_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int TICK_BITS     = TICK_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_sample_valid,
    output logic                             o_sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample,
    output logic                             o_result_valid,
    input  logic                             i_result_stall,
    output logic [TICK_BITS+FRACTION_BITS:0] o_period_q16,
    output logic [FRACTION_BITS:0]           o_crossing_fraction,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [APB_ADDR_BITS-1:0]         paddr,
    input  logic [APB_DATA_BITS-1:0]         pwdata,
    output logic [APB_DATA_BITS-1:0]         prdata,
    output logic                             pready
);

    // The only register is the warm-up length. Bit 2 of the byte address selects the
    // register word; writes to the unused word are dropped and read back as zero.
    logic [7:0] r_warmup_samples;
    logic       w_cfg_write;

    t_zcpm_cmd w_cmd;
    t_zcpm_sts w_sts;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup_samples <= WARMUP_RESET;
        end else if (w_cfg_write && (paddr[2] == REG_WARMUP)) begin
            r_warmup_samples <= pwdata[7:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_WARMUP) begin
            prdata = {{(APB_DATA_BITS - 8){1'b0}}, r_warmup_samples};
        end else begin
            prdata = '0;
        end
    end

    // The controller sequences accept, divide and finish; the result register is
    // separate from the input side so a new word can be taken while a result waits.
    zcpm_controller u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_stall (o_sample_stall),
        .o_result_valid (o_result_valid),
        .i_result_stall (i_result_stall),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd)
    );

    // The datapath holds the warm-up count, the previous sample, the tick counter,
    // the carried fraction, the divider and the result payload.
    zcpm_datapath #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .TICK_BITS     (TICK_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_sample            (i_sample),
        .i_warmup_samples    (r_warmup_samples),
        .o_period_q16        (o_period_q16),
        .o_crossing_fraction (o_crossing_fraction)
    );

endmodule

>>> design/zcpm_datapath.sv
module zcpm_datapath import zcpm_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int TICK_BITS     = TICK_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_zcpm_cmd                            i_cmd,
    output t_zcpm_sts                            o_sts,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  logic [7:0]                           i_warmup_samples,
    output logic [TICK_BITS+FRACTION_BITS:0]     o_period_q16,
    output logic [FRACTION_BITS:0]               o_crossing_fraction
);

    localparam int S      = SAMPLE_BITS;
    localparam int F      = FRACTION_BITS;
    localparam int T      = TICK_BITS;
    localparam int OW     = T + F + 1;
    localparam int PW     = T + F + 2;
    localparam int STEP_W = $clog2(F + 1);
    localparam logic [OW-1:0] PERIOD_MAX = {1'b1, {(T + F){1'b0}}};
    localparam logic [T-1:0]  TICK_MAX   = {T{1'b1}};

    logic signed [S-1:0] r_prev;
    logic [T-1:0]        r_ticks;
    logic [F:0]          r_carry;
    logic [7:0]          r_wcount;
    logic                r_warm;
    logic [S:0]          r_den;
    logic [S:0]          r_rem;
    logic [F:0]          r_quot;
    logic [STEP_W-1:0]   r_step;

    logic                 w_warm_now;
    logic                 w_prev_le0;
    logic                 w_x_gt0;
    logic                 w_trial;
    logic [S:0]           w_rem_sub;
    logic signed [PW-1:0] w_diff;
    logic [OW-1:0]        w_period;

    assign w_warm_now = r_warm || (r_wcount >= i_warmup_samples);
    assign w_prev_le0 = r_prev[S-1] || (r_prev == '0);
    assign w_x_gt0    = !i_sample[S-1] && (i_sample != '0);

    assign o_sts.crossing = w_warm_now && w_prev_le0 && w_x_gt0;
    assign o_sts.div_last = (r_step == '0);

    // Restoring division: the remainder stays below the divisor after each trial subtraction.
    assign w_trial   = (r_rem >= r_den);
    assign w_rem_sub = w_trial ? (r_rem - r_den) : r_rem;

    // Period in signed Q17.16 before saturation.
    assign w_diff = $signed(PW'(r_carry)) + $signed(PW'({r_ticks, {F{1'b0}}}))
                  - $signed(PW'(r_quot));

    always_comb begin
        if (w_diff[PW-1]) begin
            w_period = '0;
        end else if (w_diff[OW-1:0] > PERIOD_MAX) begin
            w_period = PERIOD_MAX;
        end else begin
            w_period = w_diff[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_ticks  <= '0;
            r_carry  <= '0;
            r_wcount <= '0;
            r_warm   <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (!w_warm_now) begin
                    r_wcount <= r_wcount + 8'd1;
                end else begin
                    r_warm <= 1'b1;
                    r_prev <= i_sample;
                    if (!o_sts.crossing && (r_ticks != TICK_MAX)) begin
                        r_ticks <= r_ticks + T'(1);
                    end
                end
            end
            if (i_cmd.load_out) begin
                r_carry <= r_quot;
                r_ticks <= T'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rem  <= {1'b0, i_sample};
            r_den  <= {i_sample[S-1], i_sample} - {r_prev[S-1], r_prev};
            r_quot <= '0;
            r_step <= STEP_W'(F);
        end else if (i_cmd.div_step) begin
            r_quot <= {r_quot[F-1:0], w_trial};
            r_rem  <= {w_rem_sub[S-1:0], 1'b0};
            r_step <= r_step - STEP_W'(1);
        end
        if (i_cmd.load_out) begin
            o_period_q16        <= w_period;
            o_crossing_fraction <= r_quot;
        end
    end

endmodule

>>> design/zcpm_controller.sv
module zcpm_controller import zcpm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_sample_valid,
    output logic      o_sample_stall,
    output logic      o_result_valid,
    input  logic      i_result_stall,
    input  t_zcpm_sts i_sts,
    output t_zcpm_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free     = !r_out_valid || !i_result_stall;
    assign o_sample_stall = (r_state != ST_IDLE);
    assign o_result_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_sample_valid;
                if (i_sample_valid && i_sts.crossing) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_result_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> design/zcpm_checker.sv
module zcpm_checker import zcpm_pkg::*; #(
    parameter int TICK_BITS     = TICK_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_result_valid,
    input logic                             i_result_stall,
    input logic [TICK_BITS+FRACTION_BITS:0] o_period_q16,
    input logic [FRACTION_BITS:0]           o_crossing_fraction,
    input logic                             pready
);

    localparam int OW = TICK_BITS + FRACTION_BITS + 1;
    localparam logic [OW-1:0]            PERIOD_MAX = {1'b1, {(OW - 1){1'b0}}};
    localparam logic [FRACTION_BITS:0]   FRAC_ONE   = {1'b1, {FRACTION_BITS{1'b0}}};

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result valid right after reset");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && i_result_stall |=>
            o_result_valid && $stable(o_period_q16) && $stable(o_crossing_fraction))
        else $error("stalled result changed");

    a_fraction_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_crossing_fraction != '0) && (o_crossing_fraction <= FRAC_ONE))
        else $error("crossing fraction out of range");

    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_period_q16 <= PERIOD_MAX))
        else $error("period above its upper bound");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind zero_crossing_period_meter zcpm_checker #(
    .TICK_BITS     (TICK_BITS),
    .FRACTION_BITS (FRACTION_BITS)
) u_zcpm_checker (.*);
